/* rtl/block_add_xor_checksum_assert.svh */
// ----------------------------------------------------------------------------
// block add/xor checksum assertion macros
// shared property forms for the checker, clocked and reset-gated
// ----------------------------------------------------------------------------
`ifndef BLOCK_ADD_XOR_CHECKSUM_ASSERT_SVH
`define BLOCK_ADD_XOR_CHECKSUM_ASSERT_SVH

// same-cycle implication
`define BAXC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checksum block assertion failed");

// next-cycle implication
`define BAXC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checksum block assertion failed");

`endif

/* rtl/baxc_pkg.sv */
// ----------------------------------------------------------------------------
// baxc_pkg
// types and constants shared by the add/xor checksum block
// ----------------------------------------------------------------------------
package baxc_pkg;

    localparam logic [15:0] LOW_BYTE_POS  = 16'd4;
    localparam logic [15:0] HIGH_BYTE_POS = 16'd5;
    localparam logic [15:0] POS_LIMIT     = 16'hFFFF;

    localparam logic [15:0] MAX_LENGTH_RST = 16'd4096;
    localparam logic [15:0] MIN_LENGTH_RST = 16'd32;

    typedef logic [0:0] t_cfg_index;

    localparam t_cfg_index CFG_MAX_LENGTH = 1'd0;
    localparam t_cfg_index CFG_MIN_LENGTH = 1'd1;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_first;
        logic        is_last;
        logic        mode;
        logic        has_address;
        logic [7:0]  block_address_low;
        logic [15:0] checked_length;
    } t_in_item;

    typedef struct packed {
        logic       status;
        logic [7:0] checksum_high;
        logic [7:0] checksum_low;
        logic       write_high;
        logic       write_low;
    } t_result;

endpackage

/* rtl/baxc_in_reg.sv */
// ----------------------------------------------------------------------------
// baxc_in_reg
// input register stage, holds one item until the core takes it
// ----------------------------------------------------------------------------
module baxc_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  baxc_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output baxc_pkg::t_in_item o_item
);
    import baxc_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* rtl/baxc_core.sv */
// ----------------------------------------------------------------------------
// baxc_core
// per-byte sum/xor accumulation, checksum byte capture and result register
// ----------------------------------------------------------------------------
module baxc_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  baxc_pkg::t_in_item     i_item,
    input  logic                   i_cfg_valid,
    input  baxc_pkg::t_cfg_index   i_cfg_index,
    input  logic [15:0]            i_cfg_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output baxc_pkg::t_result      o_result
);
    import baxc_pkg::*;

    logic [15:0] r_max_len;
    logic [15:0] r_min_len;

    logic [15:0] r_pos,  n_pos;
    logic [7:0]  r_add,  n_add;
    logic [7:0]  r_xor,  n_xor;
    logic [7:0]  r_slo,  n_slo;
    logic [7:0]  r_shi,  n_shi;
    logic        r_mode, n_mode;
    logic        r_av,   n_av;
    logic [7:0]  r_ab,   n_ab;
    logic        r_lbad, n_lbad;

    logic        r_out_valid;
    t_result     r_out, n_out;

    logic        adv;

    assign o_ready  = !i_item.is_last || !r_out_valid || i_ready;
    assign adv      = i_valid && o_ready;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        logic [15:0] pos;
        logic [7:0]  add_b, xor_b, slo_b, shi_b;
        logic [7:0]  delta;
        logic        skip;
        logic        pass;

        pos    = r_pos;
        add_b  = r_add;
        xor_b  = r_xor;
        slo_b  = r_slo;
        shi_b  = r_shi;
        n_mode = r_mode;
        n_av   = r_av;
        n_ab   = r_ab;
        n_lbad = r_lbad;
        pass   = 1'b0;

        // new block: sample per-block fields, seed with the address byte if present
        if (i_item.is_first) begin
            pos    = '0;
            slo_b  = '0;
            shi_b  = '0;
            n_mode = i_item.mode;
            n_av   = i_item.has_address;
            n_ab   = i_item.block_address_low;
            n_lbad = (i_item.checked_length > r_max_len) ||
                     (i_item.checked_length < r_min_len);
            add_b  = i_item.has_address ? i_item.block_address_low : 8'd0;
            xor_b  = add_b;
        end

        skip  = (pos == LOW_BYTE_POS) || (pos == HIGH_BYTE_POS);
        n_slo = (pos == LOW_BYTE_POS)  ? i_item.data_byte : slo_b;
        n_shi = (pos == HIGH_BYTE_POS) ? i_item.data_byte : shi_b;
        n_add = skip ? add_b : add_b + i_item.data_byte;
        n_xor = skip ? xor_b : xor_b ^ i_item.data_byte;
        n_pos = (pos == POS_LIMIT) ? pos : pos + 16'd1;

        delta = n_xor ^ n_slo;
        n_out = '0;
        if (n_lbad) begin
            n_out.status = 1'b1;
        end else if (!n_mode) begin
            n_out.checksum_high = n_add;
            n_out.checksum_low  = n_xor;
            n_out.write_high    = 1'b1;
            n_out.write_low     = 1'b1;
        end else begin
            if (n_av) begin
                pass = ({n_add, n_xor} == {n_shi, n_slo}) ||
                       ({n_add, n_xor} == 16'd0 && {n_shi, n_slo} == 16'd1);
            end else begin
                pass = (n_add + delta) == n_shi;
            end
            if (pass) begin
                n_out.checksum_high = n_shi;
                n_out.checksum_low  = n_av ? n_ab : delta;
                n_out.write_low     = 1'b1;
            end else begin
                n_out.status = 1'b1;
            end
        end

        // block done: clear position and accumulators
        if (i_item.is_last) begin
            n_pos = '0;
            n_add = '0;
            n_xor = '0;
            n_slo = '0;
            n_shi = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LENGTH_RST;
            r_min_len <= MIN_LENGTH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_LENGTH: r_max_len <= i_cfg_data;
                CFG_MIN_LENGTH: r_min_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_add  <= '0;
            r_xor  <= '0;
            r_slo  <= '0;
            r_shi  <= '0;
            r_mode <= 1'b0;
            r_av   <= 1'b0;
            r_ab   <= '0;
            r_lbad <= 1'b0;
        end else if (adv) begin
            r_pos  <= n_pos;
            r_add  <= n_add;
            r_xor  <= n_xor;
            r_slo  <= n_slo;
            r_shi  <= n_shi;
            r_mode <= n_mode;
            r_av   <= n_av;
            r_ab   <= n_ab;
            r_lbad <= n_lbad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && i_item.is_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_item.is_last) begin
            r_out <= n_out;
        end
    end

endmodule

/* rtl/block_add_xor_checksum.sv */
// ----------------------------------------------------------------------------
// block_add_xor_checksum
// storage block add/xor checksum generator and checker
// ----------------------------------------------------------------------------
// Takes one block byte per cycle with no gaps required, except while the input
// stalls as told below. An accepted item goes through an input register and
// then the accumulate stage with its 8-bit sum and xor feedback registers; the
// result of a block is loaded into the result register when the accumulate
// stage takes its last byte. The result register frees as it is taken, so input
// stalls only while a finished result is held and the next last byte is already
// waiting. Configuration writes are always taken.
module block_add_xor_checksum (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [31:0]          i_s_tdata,   // data_byte, block_address_low, checked_length
    input  logic [2:0]           i_s_tuser,   // is_first, mode, has_address
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [15:0]          o_m_tdata,   // checksum_high, checksum_low
    output logic [2:0]           o_m_tuser,   // status, write_high, write_low
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  baxc_pkg::t_cfg_index i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    import baxc_pkg::*;

    t_in_item s_item;
    t_in_item q_item;
    t_result  res;
    logic     q_valid;
    logic     q_ready;

    always_comb begin
        s_item.data_byte         = i_s_tdata[7:0];
        s_item.is_first          = i_s_tuser[0];
        s_item.is_last           = i_s_tlast;
        s_item.mode              = i_s_tuser[1];
        s_item.has_address       = i_s_tuser[2];
        s_item.block_address_low = i_s_tdata[15:8];
        s_item.checked_length    = i_s_tdata[31:16];
    end

    assign o_cfg_ready = 1'b1;

    baxc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (s_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    baxc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_ready     (q_ready),
        .i_item      (q_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_result    (res)
    );

    assign o_m_tdata = {res.checksum_low, res.checksum_high};
    assign o_m_tuser = {res.write_low, res.write_high, res.status};

endmodule

/* rtl/baxc_checker.sv */
// ----------------------------------------------------------------------------
// baxc_checker
// port-level checks for the add/xor checksum block
// ----------------------------------------------------------------------------
`include "block_add_xor_checksum_assert.svh"

module baxc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] i_m_tdata,
    input logic [2:0]  i_m_tuser,
    input logic        i_cfg_ready
);

    // stalled result holds
    `BAXC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))

    // error item carries nothing else
    `BAXC_ASSERT_NOW(a_err_clean, i_clk, i_rst_n, i_m_tvalid && i_m_tuser[0], i_m_tdata == 16'd0 && i_m_tuser[2:1] == 2'd0)

    // a passing item always rewrites the low byte
    `BAXC_ASSERT_NOW(a_ok_low, i_clk, i_rst_n, i_m_tvalid && !i_m_tuser[0], i_m_tuser[2])

    // config writes never stall
    `BAXC_ASSERT_NOW(a_cfg_rdy, i_clk, i_rst_n, 1'b1, i_cfg_ready)

endmodule

bind block_add_xor_checksum baxc_checker u_baxc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .i_m_tdata   (o_m_tdata),
    .i_m_tuser   (o_m_tuser),
    .i_cfg_ready (o_cfg_ready)
);

/* tb/sv/tb_block_add_xor_checksum.sv */
// ----------------------------------------------------------------------------
// tb_block_add_xor_checksum
// streams storage blocks through the add/xor checksum block in set and check
// mode and compares every result with a cycle-free prediction of the block
// ----------------------------------------------------------------------------
module tb_block_add_xor_checksum;
    import baxc_pkg::*;

    localparam logic MODE_SET   = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    localparam int FILL_MATCH    = 0;
    localparam int FILL_BROKEN   = 1;
    localparam int FILL_RANDOM   = 2;
    localparam int FILL_OPEN     = 3;
    localparam int FILL_ZERO_ONE = 4;
    localparam int FILL_ONES     = 5;

    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 8;

    class checksum_tracker;
        logic [15:0] max_len;
        logic [15:0] min_len;
        logic [15:0] pos;
        logic [7:0]  add_acc;
        logic [7:0]  xor_acc;
        logic [7:0]  cap_low;
        logic [7:0]  cap_high;
        logic [7:0]  addr_byte;
        logic        blk_mode;
        logic        addr_ok;
        logic        len_bad;
        t_result     verdicts_due[$];
        int          errors;

        function new();
            max_len   = MAX_LENGTH_RST;
            min_len   = MIN_LENGTH_RST;
            blk_mode  = 1'b0;
            addr_ok   = 1'b0;
            addr_byte = 8'h00;
            len_bad   = 1'b0;
            errors    = 0;
            clear_accumulators();
        endfunction

        function void clear_accumulators();
            pos      = 16'd0;
            add_acc  = 8'h00;
            xor_acc  = 8'h00;
            cap_low  = 8'h00;
            cap_high = 8'h00;
        endfunction

        function void set_register(t_cfg_index idx, logic [15:0] value);
            if (idx == CFG_MAX_LENGTH) begin
                max_len = value;
            end else begin
                min_len = value;
            end
        endfunction

        function void absorb_byte(t_in_item it);
            t_result     r;
            logic        skip;
            logic [15:0] now_cs;
            logic [15:0] was_cs;
            logic [7:0]  delta;
            skip = 1'b0;
            if (it.is_first) begin
                clear_accumulators();
                blk_mode  = it.mode;
                addr_ok   = it.has_address;
                addr_byte = it.block_address_low;
                len_bad   = (it.checked_length > max_len) || (it.checked_length < min_len);
                if (addr_ok) begin
                    add_acc = addr_byte;
                    xor_acc = addr_byte;
                end
            end
            if (pos == LOW_BYTE_POS) begin
                cap_low = it.data_byte;
                skip    = 1'b1;
            end
            if (pos == HIGH_BYTE_POS) begin
                cap_high = it.data_byte;
                skip     = 1'b1;
            end
            if (!skip) begin
                add_acc = add_acc + it.data_byte;
                xor_acc = xor_acc ^ it.data_byte;
            end
            if (pos != POS_LIMIT) begin
                pos = pos + 16'd1;
            end
            if (!it.is_last) begin
                return;
            end
            r      = '0;
            now_cs = {add_acc, xor_acc};
            was_cs = {cap_high, cap_low};
            delta  = xor_acc ^ cap_low;
            if (len_bad) begin
                r.status = 1'b1;
            end else if (blk_mode == MODE_SET) begin
                r.checksum_high = add_acc;
                r.checksum_low  = xor_acc;
                r.write_high    = 1'b1;
                r.write_low     = 1'b1;
            end else if (addr_ok) begin
                if (now_cs == was_cs || (now_cs == 16'd0 && was_cs == 16'd1)) begin
                    r.checksum_high = cap_high;
                    r.checksum_low  = addr_byte;
                    r.write_low     = 1'b1;
                end else begin
                    r.status = 1'b1;
                end
            end else if (8'(add_acc + delta) == cap_high) begin
                r.checksum_high = cap_high;
                r.checksum_low  = delta;
                r.write_low     = 1'b1;
            end else begin
                r.status = 1'b1;
            end
            verdicts_due.push_back(r);
            clear_accumulators();
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (verdicts_due.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            compare_field("status", 8'(want.status), 8'(got.status));
            compare_field("checksum_high", want.checksum_high, got.checksum_high);
            compare_field("checksum_low", want.checksum_low, got.checksum_low);
            compare_field("write_high", 8'(want.write_high), 8'(got.write_high));
            compare_field("write_low", 8'(want.write_low), 8'(got.write_low));
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata   = '0;    // data_byte, block_address_low, checked_length
    logic [2:0]  i_s_tuser   = '0;    // is_first, mode, has_address
    logic        i_s_tlast   = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [15:0] o_m_tdata;           // checksum_high, checksum_low
    logic [2:0]  o_m_tuser;           // status, write_high, write_low
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_cfg_index  i_cfg_index = CFG_MAX_LENGTH;
    logic [15:0] i_cfg_data  = '0;

    checksum_tracker sb = new();

    int items_sent = 0;
    int burst_left = 0;
    int quiet      = 0;
    int rx_mode    = 0;
    int rx_hold    = 0;

    block_add_xor_checksum dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // receiver stall pattern, switching between free flow, short and long stalls
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) begin
            rx_mode = $urandom_range(0, 2);
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_m_tready <= 1'b0;
        end else if (rx_mode == 1) begin
            i_m_tready <= ($urandom_range(0, 2) != 0);
        end else if (rx_mode == 2 && $urandom_range(0, 9) == 0) begin
            rx_hold = $urandom_range(1, 25);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result res;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            res.status        = o_m_tuser[0];
            res.write_high    = o_m_tuser[1];
            res.write_low     = o_m_tuser[2];
            res.checksum_high = o_m_tdata[7:0];
            res.checksum_low  = o_m_tdata[15:8];
            sb.match_result(res);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(input t_in_item it);
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {it.checked_length, it.block_address_low, it.data_byte};
        i_s_tuser  <= {it.has_address, it.mode, it.is_first};
        i_s_tlast  <= it.is_last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.absorb_byte(it);
        items_sent++;
    endtask

    // sender bursts with random gaps in between
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    task automatic send_loose(input logic last);
        t_in_item it;
        {it.data_byte, it.block_address_low, it.checked_length} = $urandom;
        {it.mode, it.has_address} = 2'($urandom);
        it.is_first = 1'b0;
        it.is_last  = last;
        send_item(it);
        pace();
    endtask

    task automatic send_block(input logic md, input logic ha, input logic [7:0] addr,
                              input logic [15:0] len, input int n, input int fill);
        logic [7:0] blk[];
        logic [7:0] s;
        logic [7:0] x;
        t_in_item   it;
        int         k;
        blk = new[n];
        foreach (blk[i]) begin
            blk[i] = (fill == FILL_ONES) ? 8'hFF : (fill == FILL_ZERO_ONE) ? 8'h00 : 8'($urandom);
        end
        if (fill == FILL_ZERO_ONE && n > LOW_BYTE_POS) begin
            blk[LOW_BYTE_POS] = 8'h01;
        end
        if ((fill == FILL_MATCH || fill == FILL_BROKEN) && n > HIGH_BYTE_POS) begin
            s = ha ? addr : 8'h00;
            x = s;
            foreach (blk[i]) begin
                if (i != LOW_BYTE_POS && i != HIGH_BYTE_POS) begin
                    s = s + blk[i];
                    x = x ^ blk[i];
                end
            end
            if (ha) begin
                blk[LOW_BYTE_POS]  = x;
                blk[HIGH_BYTE_POS] = s;
            end else begin
                blk[HIGH_BYTE_POS] = s + (x ^ blk[LOW_BYTE_POS]);
            end
            if (fill == FILL_BROKEN) begin
                k = $urandom_range(0, n - 1);
                blk[k][$urandom_range(0, 7)] ^= 1'b1;
            end
        end
        for (int i = 0; i < n; i++) begin
            {it.block_address_low, it.checked_length} = 24'($urandom);
            {it.mode, it.has_address} = 2'($urandom);
            if (i == 0) begin
                it.mode              = md;
                it.has_address       = ha;
                it.block_address_low = addr;
                it.checked_length    = len;
            end
            it.data_byte = blk[i];
            it.is_first  = (i == 0);
            it.is_last   = (i == n - 1) && (fill != FILL_OPEN);
            send_item(it);
            pace();
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_register(idx, value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int goal);
        logic        md;
        logic        ha;
        logic [15:0] len;
        logic [16:0] wide;
        int          n;
        int          pick;
        int          fill;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(1, 4)) send_loose($urandom_range(0, 3) == 0);
            end else begin
                n  = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
                md = 1'($urandom);
                ha = 1'($urandom);
                if ($urandom_range(0, 4) != 0 && sb.min_len <= sb.max_len) begin
                    len = 16'($urandom_range(sb.min_len, sb.max_len));
                end else begin
                    case ($urandom_range(0, 4))
                        0: begin
                            wide = 17'(sb.max_len) + 17'd1;
                            len  = wide[15:0];
                        end
                        1: len = sb.min_len - 16'd1;
                        2: len = 16'd0;
                        3: len = 16'hFFFF;
                        default: len = 16'($urandom);
                    endcase
                end
                pick = $urandom_range(0, 19);
                fill = (pick < 12) ? FILL_MATCH : (pick < 15) ? FILL_BROKEN :
                       (pick < 17) ? FILL_RANDOM : (pick < 19) ? FILL_OPEN : FILL_ZERO_ONE;
                send_block(md, ha, (fill == FILL_ZERO_ONE) ? 8'h00 : 8'($urandom), len, n, fill);
            end
        end
    endtask

    initial begin
        logic [15:0] hi_len;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // loose bytes with no first mark, then short directed blocks
        send_loose(1'b0);
        send_loose(1'b1);
        send_block(MODE_SET, 1'b1, 8'hFF, 16'd4096, 6, FILL_ONES);
        send_block(MODE_CHECK, 1'b1, 8'h00, 16'd32, 6, FILL_ZERO_ONE);
        send_block(MODE_CHECK, 1'b0, 8'h3C, 16'd32, 6, FILL_MATCH);
        send_block(MODE_CHECK, 1'b1, 8'h5A, 16'd0, 1, FILL_RANDOM);
        send_block(MODE_CHECK, 1'b0, 8'hA5, 16'hFFFF, 3, FILL_RANDOM);

        run_random(items_sent + 200);

        for (int ph = 1; ph < 8; ph++) begin
            wait_idle();
            case (ph)
                1: begin
                    write_register(CFG_MAX_LENGTH, 16'hFFFF);
                    write_register(CFG_MIN_LENGTH, 16'h0000);
                end
                2: begin
                    write_register(CFG_MAX_LENGTH, 16'h0000);
                end
                3: begin
                    write_register(CFG_MAX_LENGTH, 16'd100);
                    write_register(CFG_MIN_LENGTH, 16'd200);
                end
                4: begin
                    write_register(CFG_MAX_LENGTH, 16'hFFFF);
                    write_register(CFG_MIN_LENGTH, 16'hFFFF);
                end
                default: begin
                    hi_len = 16'($urandom);
                    write_register(CFG_MAX_LENGTH, hi_len);
                    write_register(CFG_MIN_LENGTH, 16'($urandom_range(0, hi_len)));
                end
            endcase
            run_random(items_sent + 230);
        end

        wait_idle();
        if (sb.verdicts_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.verdicts_due.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
